[sv/ssq_pkg.sv]
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types, widths and codes for the swing step sequencer.
// ----------------------------------------------------------------------------
package ssq_pkg;

    localparam int MAX_STEPS  = 32;
    localparam int STEP_IDX_W = $clog2(MAX_STEPS);
    localparam int NSTEP_W    = $clog2(MAX_STEPS + 1);
    localparam int MODV_W     = $clog2(2 * MAX_STEPS);
    localparam int MOD_STEPS  = $clog2(MAX_STEPS) - 1;
    localparam int MOD_CNT_W  = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
    localparam int SUB_W      = NSTEP_W + MOD_STEPS;
    localparam int PP_W       = STEP_IDX_W + 2;

    localparam int PERIOD_W   = 24;
    localparam int LEN_W      = PERIOD_W + 1;
    localparam int VAL_W      = 16;
    localparam int MEM_W      = 32;
    localparam int LEVEL_W    = 17;
    localparam int MUL_A_W    = 34;
    localparam int MUL_B_W    = 18;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [VAL_W-1:0] VALUE_MAX = 16'd32768;

    // word actions
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_WRITE   = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // step order
    localparam logic [1:0] DIR_FWD  = 2'd0;
    localparam logic [1:0] DIR_REV  = 2'd1;
    localparam logic [1:0] DIR_PING = 2'd2;
    localparam logic [1:0] DIR_RAND = 2'd3;

    // configuration register map
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_STEPS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWING     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIPOLAR  = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_CHECK,
        ST_MOD,
        ST_SWING,
        ST_LEN,
        ST_READ,
        ST_HOLD,
        ST_GATE,
        ST_TGT,
        ST_SLEW,
        ST_UPD,
        ST_EMIT,
        ST_ZERO
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_WRITE,
        OP_RESTART,
        OP_START,
        OP_CHECK,
        OP_MOD,
        OP_SWING,
        OP_LEN,
        OP_READ,
        OP_HOLD,
        OP_GATE,
        OP_TGT,
        OP_SLEW,
        OP_UPD,
        OP_EMIT,
        OP_ZERO
    } dp_op_t;

    typedef struct packed {
        dp_op_t               op;
        logic [MOD_CNT_W-1:0] mod_k;
        logic                 pick_load;
    } ctrl_t;

    typedef struct packed {
        logic enabled;
        logic elapsed_ge;
        logic reload;
    } sts_t;

endpackage

[sv/swing_step_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// swing_step_sequencer_unit
// Modulation step sequencer with swing, gate, slew and polarity output.
// ----------------------------------------------------------------------------
// Each tick word returns one Q15 level on the m_ channel; write and restart
// words return nothing. A disabled tick goes to ZERO, which gives its level as
// the input reopens. An enabled tick passes START and CHECK, then on an advance
// MOD, SWING and LEN, then READ and HOLD on an advance or when the step value
// is loaded after reset or restart, then GATE, TGT, SLEW, UPD and EMIT; its
// level appears as the input reopens. It runs through one shared 34x18
// multiplier (swing length on an advance, gate threshold and slew on every
// tick) and a compare-subtract unit four times to reduce the next step index,
// plus a registered read of the step memory. s_ready is low while a tick is in
// flight; a finished level waits in the output register until it is taken,
// holding the next tick at EMIT or ZERO. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module swing_step_sequencer_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_action,
    input  logic [4:0]                          s_step_index,
    input  logic [15:0]                         s_step_value,
    input  logic [4:0]                          s_random_pick,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ssq_pkg::LEVEL_W-1:0]  m_level_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ssq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ssq_pkg::CFG_DATA_W-1:0]      cfg_data
);

    ssq_pkg::ctrl_t ctrl;
    ssq_pkg::sts_t  sts;

    assign cfg_ready = 1'b1;

    ssq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .m_ready  (m_ready),
        .sts      (sts),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .ctrl     (ctrl)
    );

    ssq_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_step_index  (s_step_index),
        .s_step_value  (s_step_value),
        .s_random_pick (s_random_pick),
        .sts           (sts),
        .level_out     (m_level_out)
    );

endmodule

[sv/ssq_ctrl.sv]
// ----------------------------------------------------------------------------
// ssq_ctrl
// Sequencer: walks one tick through the shared datapath, owns the handshakes.
// ----------------------------------------------------------------------------
module ssq_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic [1:0]      s_action,
    input  logic            m_ready,
    input  ssq_pkg::sts_t   sts,
    output logic            s_ready,
    output logic            m_valid,
    output ssq_pkg::ctrl_t  ctrl
);

    ssq_pkg::state_t state_reg, state_next;
    logic [ssq_pkg::MOD_CNT_W-1:0] mod_cnt_reg, mod_cnt_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;
    logic accept;
    logic emit_fire;

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = (state_reg == ssq_pkg::ST_IDLE) && s_valid;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ssq_pkg::ST_IDLE: begin
                if (s_valid && s_action == ssq_pkg::ACT_TICK) begin
                    state_next = sts.enabled ? ssq_pkg::ST_START : ssq_pkg::ST_ZERO;
                end
            end
            ssq_pkg::ST_START: state_next = ssq_pkg::ST_CHECK;
            ssq_pkg::ST_CHECK: begin
                priority if (sts.elapsed_ge) begin
                    state_next = ssq_pkg::ST_MOD;
                end else if (sts.reload) begin
                    state_next = ssq_pkg::ST_READ;
                end else begin
                    state_next = ssq_pkg::ST_GATE;
                end
            end
            ssq_pkg::ST_MOD: begin
                if (mod_cnt_reg == '0) begin
                    state_next = ssq_pkg::ST_SWING;
                end
            end
            ssq_pkg::ST_SWING: state_next = ssq_pkg::ST_LEN;
            ssq_pkg::ST_LEN:   state_next = ssq_pkg::ST_READ;
            ssq_pkg::ST_READ:  state_next = ssq_pkg::ST_HOLD;
            ssq_pkg::ST_HOLD:  state_next = ssq_pkg::ST_GATE;
            ssq_pkg::ST_GATE:  state_next = ssq_pkg::ST_TGT;
            ssq_pkg::ST_TGT:   state_next = ssq_pkg::ST_SLEW;
            ssq_pkg::ST_SLEW:  state_next = ssq_pkg::ST_UPD;
            ssq_pkg::ST_UPD:   state_next = ssq_pkg::ST_EMIT;
            ssq_pkg::ST_EMIT, ssq_pkg::ST_ZERO: begin
                if (out_free) begin
                    state_next = ssq_pkg::ST_IDLE;
                end
            end
            default: state_next = ssq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl.op        = ssq_pkg::OP_NONE;
        ctrl.mod_k     = mod_cnt_reg;
        ctrl.pick_load = 1'b0;
        emit_fire      = 1'b0;
        unique case (state_reg)
            ssq_pkg::ST_IDLE: begin
                ctrl.pick_load = accept && s_action == ssq_pkg::ACT_TICK;
                if (accept && s_action == ssq_pkg::ACT_WRITE) begin
                    ctrl.op = ssq_pkg::OP_WRITE;
                end else if (accept && s_action == ssq_pkg::ACT_RESTART) begin
                    ctrl.op = ssq_pkg::OP_RESTART;
                end
            end
            ssq_pkg::ST_START: ctrl.op = ssq_pkg::OP_START;
            ssq_pkg::ST_CHECK: ctrl.op = ssq_pkg::OP_CHECK;
            ssq_pkg::ST_MOD:   ctrl.op = ssq_pkg::OP_MOD;
            ssq_pkg::ST_SWING: ctrl.op = ssq_pkg::OP_SWING;
            ssq_pkg::ST_LEN:   ctrl.op = ssq_pkg::OP_LEN;
            ssq_pkg::ST_READ:  ctrl.op = ssq_pkg::OP_READ;
            ssq_pkg::ST_HOLD:  ctrl.op = ssq_pkg::OP_HOLD;
            ssq_pkg::ST_GATE:  ctrl.op = ssq_pkg::OP_GATE;
            ssq_pkg::ST_TGT:   ctrl.op = ssq_pkg::OP_TGT;
            ssq_pkg::ST_SLEW:  ctrl.op = ssq_pkg::OP_SLEW;
            ssq_pkg::ST_UPD:   ctrl.op = ssq_pkg::OP_UPD;
            ssq_pkg::ST_EMIT: begin
                if (out_free) begin
                    ctrl.op   = ssq_pkg::OP_EMIT;
                    emit_fire = 1'b1;
                end
            end
            ssq_pkg::ST_ZERO: begin
                if (out_free) begin
                    ctrl.op   = ssq_pkg::OP_ZERO;
                    emit_fire = 1'b1;
                end
            end
            default: ctrl.op = ssq_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        mod_cnt_next = mod_cnt_reg;
        if (state_reg == ssq_pkg::ST_CHECK) begin
            mod_cnt_next = ssq_pkg::MOD_CNT_W'(ssq_pkg::MOD_STEPS - 1);
        end else if (state_reg == ssq_pkg::ST_MOD && mod_cnt_reg != '0) begin
            mod_cnt_next = mod_cnt_reg - 1'b1;
        end
    end

    assign m_valid_next = (m_valid_reg && !m_ready) || emit_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ssq_pkg::ST_IDLE;
            mod_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mod_cnt_reg <= mod_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ssq_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[sv/ssq_datapath.sv]
// ----------------------------------------------------------------------------
// ssq_datapath
// Config registers, step memory, sequencer state and the shared multiplier.
// ----------------------------------------------------------------------------
module ssq_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ssq_pkg::ctrl_t                       ctrl,
    input  logic                                 cfg_valid,
    input  logic [ssq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ssq_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [4:0]                           s_step_index,
    input  logic [15:0]                          s_step_value,
    input  logic [4:0]                           s_random_pick,
    output ssq_pkg::sts_t                        sts,
    output logic signed [ssq_pkg::LEVEL_W-1:0]   level_out
);

    // configuration
    logic        enabled_reg;
    logic [5:0]  num_steps_reg;
    logic [ssq_pkg::PERIOD_W-1:0] period_reg;
    logic [9:0]  swing_reg;
    logic [10:0] gate_reg;
    logic [16:0] coef_reg;
    logic [1:0]  direction_reg;
    logic        unipolar_reg;

    logic [ssq_pkg::NSTEP_W-1:0]  n_eff;
    logic [ssq_pkg::PERIOD_W-1:0] period_eff;
    logic [9:0]  swing_eff;
    logic [10:0] gate_eff;
    logic [16:0] coef_eff;

    // sequencer state
    logic [ssq_pkg::STEP_IDX_W-1:0] pos_reg;
    logic                           up_reg;
    logic [ssq_pkg::LEN_W-1:0]      elapsed_reg;
    logic [ssq_pkg::LEN_W-1:0]      length_reg;
    logic                           pending_reg;
    logic                           reload_reg;
    logic [ssq_pkg::VAL_W-1:0]      held_reg;
    logic [ssq_pkg::MEM_W-1:0]      mem_reg;
    logic [ssq_pkg::MAX_STEPS-1:0]  valid_reg;

    // working registers
    logic [4:0]                     pick_reg;
    logic [ssq_pkg::MODV_W-1:0]     modv_reg;
    logic signed [ssq_pkg::PROD_W-1:0] prod_reg;
    logic [ssq_pkg::VAL_W-1:0]      target_reg;
    logic [ssq_pkg::VAL_W-1:0]      rd_data_reg;
    logic                           rd_valid_reg;
    logic signed [ssq_pkg::LEVEL_W-1:0] level_reg;

    logic [ssq_pkg::VAL_W-1:0] step_mem [ssq_pkg::MAX_STEPS];

    // combinational helpers
    logic                              wr_ok;
    logic [ssq_pkg::STEP_IDX_W-1:0]    wr_addr;
    logic [ssq_pkg::VAL_W-1:0]         wr_val;
    logic [ssq_pkg::MODV_W-1:0]        adv_val;
    logic                              adv_up;
    logic signed [ssq_pkg::PP_W-1:0]   pp_base;
    logic signed [ssq_pkg::PP_W-1:0]   pp_next;
    logic signed [ssq_pkg::PP_W-1:0]   pp_last;
    logic [ssq_pkg::SUB_W-1:0]         mod_dvs;
    logic [ssq_pkg::SUB_W-1:0]         mod_val;
    logic [ssq_pkg::PERIOD_W-1:0]      swing_d;
    logic [ssq_pkg::LEN_W-1:0]         len_calc;
    logic [ssq_pkg::LEN_W+9:0]         elapsed_sh;
    logic signed [ssq_pkg::MUL_A_W-1:0] slew_diff;
    logic signed [ssq_pkg::MUL_A_W-1:0] mul_a;
    logic signed [ssq_pkg::MUL_B_W-1:0] mul_b;
    logic signed [ssq_pkg::PROD_W-1:0]  mul_p;
    logic signed [ssq_pkg::MEM_W+3:0]   mem_sum;
    logic [15:0]                       lvl_u;

    // ---- configuration port ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg   <= 1'b0;
            num_steps_reg <= 6'd16;
            period_reg    <= 24'd12000;
            swing_reg     <= 10'd0;
            gate_reg      <= 11'd819;
            coef_reg      <= 17'd65536;
            direction_reg <= ssq_pkg::DIR_FWD;
            unipolar_reg  <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ssq_pkg::CFG_ENABLED:   enabled_reg   <= cfg_data[0];
                ssq_pkg::CFG_NUM_STEPS: num_steps_reg <= cfg_data[5:0];
                ssq_pkg::CFG_PERIOD:    period_reg    <= cfg_data[ssq_pkg::PERIOD_W-1:0];
                ssq_pkg::CFG_SWING:     swing_reg     <= cfg_data[9:0];
                ssq_pkg::CFG_GATE:      gate_reg      <= cfg_data[10:0];
                ssq_pkg::CFG_SLEW:      coef_reg      <= cfg_data[16:0];
                ssq_pkg::CFG_DIRECTION: direction_reg <= cfg_data[1:0];
                ssq_pkg::CFG_UNIPOLAR:  unipolar_reg  <= cfg_data[0];
            endcase
        end
    end

    // clamped working values
    always_comb begin
        if ({1'b0, num_steps_reg} > 7'(ssq_pkg::MAX_STEPS)) begin
            n_eff = ssq_pkg::NSTEP_W'(ssq_pkg::MAX_STEPS);
        end else if (num_steps_reg < 6'd4) begin
            n_eff = ssq_pkg::NSTEP_W'(4);
        end else begin
            n_eff = ssq_pkg::NSTEP_W'(num_steps_reg);
        end
        period_eff = (period_reg < 24'd4) ? 24'd4 : period_reg;
        swing_eff  = (swing_reg > 10'd614) ? 10'd614 : swing_reg;
        if (gate_reg < 11'd51) begin
            gate_eff = 11'd51;
        end else if (gate_reg > 11'd1024) begin
            gate_eff = 11'd1024;
        end else begin
            gate_eff = gate_reg;
        end
        if (coef_reg == 17'd0) begin
            coef_eff = 17'd1;
        end else if (coef_reg > 17'd65536) begin
            coef_eff = 17'd65536;
        end else begin
            coef_eff = coef_reg;
        end
    end

    // ---- step memory ----
    assign wr_ok   = (32'(s_step_index) < ssq_pkg::MAX_STEPS);
    assign wr_addr = ssq_pkg::STEP_IDX_W'(s_step_index);
    assign wr_val  = (s_step_value > ssq_pkg::VALUE_MAX) ? ssq_pkg::VALUE_MAX : s_step_value;

    always_ff @(posedge aclk) begin
        if (ctrl.op == ssq_pkg::OP_WRITE && wr_ok) begin
            step_mem[wr_addr] <= wr_val;
        end
        if (ctrl.op == ssq_pkg::OP_READ) begin
            rd_data_reg <= step_mem[pos_reg];
        end
    end

    // ---- next position before reduction ----
    assign pp_base = $signed({2'b00, pos_reg});
    assign pp_next = up_reg ? pp_base + ssq_pkg::PP_W'(1) : pp_base - ssq_pkg::PP_W'(1);
    assign pp_last = $signed({1'b0, n_eff - 1'b1});

    always_comb begin
        adv_up  = up_reg;
        adv_val = '0;
        unique case (direction_reg)
            ssq_pkg::DIR_FWD: begin
                adv_val = ssq_pkg::MODV_W'(pos_reg) + 1'b1;
            end
            ssq_pkg::DIR_REV: begin
                adv_val = ssq_pkg::MODV_W'(pos_reg) + ssq_pkg::MODV_W'(n_eff) - 1'b1;
            end
            ssq_pkg::DIR_PING: begin
                // ends clamp and turn; an out-of-range position clamps to the last step
                priority if (pp_next >= pp_last) begin
                    adv_val = ssq_pkg::MODV_W'(pp_last);
                    adv_up  = 1'b0;
                end else if (pp_next <= 0) begin
                    adv_val = '0;
                    adv_up  = 1'b1;
                end else begin
                    adv_val = ssq_pkg::MODV_W'(pp_next);
                end
            end
            ssq_pkg::DIR_RAND: begin
                adv_val = ssq_pkg::MODV_W'(pick_reg);
            end
        endcase
    end

    // restoring reduction, one shifted divisor per cycle
    assign mod_dvs = ssq_pkg::SUB_W'(n_eff) << ctrl.mod_k;
    assign mod_val = ssq_pkg::SUB_W'(modv_reg);

    // ---- step length from swing ----
    assign swing_d = prod_reg[ssq_pkg::PERIOD_W+9:10];

    always_comb begin
        if (pos_reg[0]) begin
            len_calc = {1'b0, period_eff} + {1'b0, swing_d};
        end else begin
            len_calc = {1'b0, period_eff} - {1'b0, swing_d};
        end
        if (len_calc == '0) begin
            len_calc = {1'b0, period_eff};
        end
    end

    // ---- shared multiplier ----
    assign elapsed_sh = {elapsed_reg, 10'b0};
    assign slew_diff  = $signed({2'b00, target_reg, 16'b0}) - $signed({2'b00, mem_reg});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.op)
            ssq_pkg::OP_SWING: begin
                mul_a = $signed({10'b0, period_eff});
                mul_b = $signed({8'b0, swing_eff});
            end
            ssq_pkg::OP_GATE: begin
                mul_a = $signed({9'b0, length_reg});
                mul_b = $signed({7'b0, gate_eff});
            end
            ssq_pkg::OP_SLEW: begin
                mul_a = slew_diff;
                mul_b = $signed({1'b0, coef_eff});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    // floor of the product over 2^16
    assign mem_sum = $signed({4'b0, mem_reg}) + prod_reg[ssq_pkg::PROD_W-1:16];
    assign lvl_u   = mem_reg[31:16];

    // ---- working registers, no reset ----
    always_ff @(posedge aclk) begin
        if (ctrl.op == ssq_pkg::OP_CHECK) begin
            modv_reg <= adv_val;
        end else if (ctrl.op == ssq_pkg::OP_MOD && mod_val >= mod_dvs) begin
            modv_reg <= ssq_pkg::MODV_W'(mod_val - mod_dvs);
        end
        if (ctrl.op == ssq_pkg::OP_SWING || ctrl.op == ssq_pkg::OP_GATE ||
            ctrl.op == ssq_pkg::OP_SLEW) begin
            prod_reg <= mul_p;
        end
        if (ctrl.op == ssq_pkg::OP_TGT) begin
            target_reg <= ({17'b0, elapsed_sh} < $unsigned(prod_reg)) ? held_reg : '0;
        end
        if (ctrl.op == ssq_pkg::OP_EMIT) begin
            if (unipolar_reg) begin
                level_reg <= $signed({1'b0, lvl_u});
            end else begin
                level_reg <= $signed({lvl_u, 1'b0} - 17'd32768);
            end
        end else if (ctrl.op == ssq_pkg::OP_ZERO) begin
            level_reg <= '0;
        end
    end

    // pick is latched with the tick word
    always_ff @(posedge aclk) begin
        if (ctrl.pick_load) begin
            pick_reg <= s_random_pick;
        end
    end

    // ---- sequencer state ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            up_reg       <= 1'b1;
            elapsed_reg  <= '0;
            length_reg   <= '0;
            pending_reg  <= 1'b1;
            reload_reg   <= 1'b0;
            held_reg     <= '0;
            mem_reg      <= '0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            unique case (ctrl.op)
                ssq_pkg::OP_WRITE: begin
                    if (wr_ok) begin
                        valid_reg[wr_addr] <= 1'b1;
                    end
                end
                ssq_pkg::OP_RESTART: begin
                    elapsed_reg <= '0;
                    pending_reg <= 1'b1;
                    pos_reg     <= '0;
                    up_reg      <= 1'b1;
                    mem_reg     <= '0;
                end
                ssq_pkg::OP_START: begin
                    elapsed_reg <= elapsed_reg + 1'b1;
                    if (pending_reg) begin
                        length_reg  <= {1'b0, period_eff};
                        pending_reg <= 1'b0;
                        reload_reg  <= 1'b1;
                    end
                end
                ssq_pkg::OP_CHECK: begin
                    if (sts.elapsed_ge) begin
                        elapsed_reg <= elapsed_reg - length_reg;
                        up_reg      <= adv_up;
                    end
                end
                ssq_pkg::OP_SWING: begin
                    pos_reg <= ssq_pkg::STEP_IDX_W'(modv_reg);
                end
                ssq_pkg::OP_LEN: begin
                    length_reg <= len_calc;
                    reload_reg <= 1'b1;
                end
                ssq_pkg::OP_READ: begin
                    rd_valid_reg <= valid_reg[pos_reg];
                end
                ssq_pkg::OP_HOLD: begin
                    held_reg   <= rd_valid_reg ? rd_data_reg : '0;
                    reload_reg <= 1'b0;
                end
                ssq_pkg::OP_UPD: begin
                    mem_reg <= mem_sum[ssq_pkg::MEM_W-1:0];
                end
                default: ;
            endcase
        end
    end

    assign sts.enabled    = enabled_reg;
    assign sts.elapsed_ge = (elapsed_reg >= length_reg);
    assign sts.reload     = reload_reg;
    assign level_out      = level_reg;

endmodule

[sv/ssq_checker.sv]
// ----------------------------------------------------------------------------
// ssq_checker
// Port-level checks for the swing step sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module ssq_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic [1:0]                          s_action,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [ssq_pkg::LEVEL_W-1:0]  m_level_out
);

    // level never leaves the Q15 range
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_level_out >= -17'sd32768 && m_level_out <= 17'sd32768))
        else $error("level out of range");

    // a tick keeps the input closed for at least the next cycle
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_action == ssq_pkg::ACT_TICK) |=> !s_ready)
        else $error("input reopened right after a tick");

    // write, restart and unused words never raise a result
    a_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_action != ssq_pkg::ACT_TICK && !m_valid) |=> !m_valid)
        else $error("result raised by a non-tick word");

    // a waiting result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_level_out)))
        else $error("result dropped or changed while stalled");

endmodule

bind swing_step_sequencer_unit ssq_checker u_ssq_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_action    (s_action),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_level_out (m_level_out)
);

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for swing_step_sequencer_unit.
// ----------------------------------------------------------------------------
// A directed table runs first: disabled ticks, table writes with saturation,
// restart while disabled, an unused action, then a short enabled run. Random
// phases follow. Each phase programs every register, including clamped
// extremes, and then sends a mix of ticks, writes and restarts. Levels are
// predicted by a local copy of the sequencer and compared in order. Both
// sides insert random gaps, and one phase holds the level sink off for a long
// stretch.
// ----------------------------------------------------------------------------
module tb;
    import ssq_pkg::*;

    localparam logic [1:0] ACT_UNUSED      = 2'd3;
    localparam int         RAND_PHASES     = 24;
    localparam int         WORDS_PER_PHASE = 64;
    localparam int         PRESSURE_PHASE  = 7;
    localparam int         HOLD_CYCLES     = 120;
    localparam int         DRAIN_CYCLES    = 24;
    localparam int         WATCHDOG_LIMIT  = 3000;
    localparam int         ENABLE_SPLIT    = 9;
    localparam int         NUM_ROWS        = 23;

    typedef struct packed {
        logic [1:0]         act;
        logic [4:0]         idx;
        logic [15:0]        val;
        logic [4:0]         pick;
        logic               typed;
        logic [LEVEL_W-1:0] lvl;
    } stim_row_t;

    // rows before ENABLE_SPLIT run at reset settings (disabled)
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{ACT_TICK,    5'd0,  16'd0,     5'd0,  1'b1, 17'd0},
        '{ACT_WRITE,   5'd0,  16'd32768, 5'd0,  1'b0, 17'd0},
        '{ACT_WRITE,   5'd31, 16'hFFFF,  5'd31, 1'b0, 17'd0},
        '{ACT_WRITE,   5'd1,  16'd0,     5'd0,  1'b0, 17'd0},
        '{ACT_WRITE,   5'd2,  16'd16384, 5'd0,  1'b0, 17'd0},
        '{ACT_WRITE,   5'd3,  16'd1,     5'd0,  1'b0, 17'd0},
        '{ACT_RESTART, 5'd0,  16'd0,     5'd0,  1'b0, 17'd0},
        '{ACT_UNUSED,  5'd31, 16'hFFFF,  5'd31, 1'b0, 17'd0},
        '{ACT_TICK,    5'd0,  16'd0,     5'd0,  1'b1, 17'd0},
        '{ACT_TICK,    5'd0,  16'd0,     5'd31, 1'b1, 17'd32768},
        '{ACT_TICK,    5'd0,  16'd0,     5'd1,  1'b0, 17'd0},
        '{ACT_TICK,    5'd0,  16'd0,     5'd2,  1'b0, 17'd0},
        '{ACT_TICK,    5'd0,  16'd0,     5'd4,  1'b0, 17'd0},
        '{ACT_TICK,    5'd0,  16'd0,     5'd8,  1'b0, 17'd0},
        '{ACT_TICK,    5'd0,  16'd0,     5'd16, 1'b0, 17'd0},
        '{ACT_TICK,    5'd0,  16'd0,     5'd0,  1'b0, 17'd0},
        '{ACT_TICK,    5'd0,  16'd0,     5'd0,  1'b0, 17'd0},
        '{ACT_WRITE,   5'd0,  16'd0,     5'd0,  1'b0, 17'd0},
        '{ACT_TICK,    5'd0,  16'd0,     5'd0,  1'b0, 17'd0},
        '{ACT_TICK,    5'd0,  16'd0,     5'd0,  1'b0, 17'd0},
        '{ACT_RESTART, 5'd0,  16'd0,     5'd0,  1'b0, 17'd0},
        '{ACT_TICK,    5'd0,  16'd0,     5'd0,  1'b1, 17'd0},
        '{ACT_TICK,    5'd0,  16'd0,     5'd0,  1'b0, 17'd0}
    };

    logic                        aclk          = 1'b0;
    logic                        aresetn       = 1'b0;
    logic                        s_valid       = 1'b0;
    logic                        s_ready;
    logic [1:0]                  s_action      = ACT_TICK;
    logic [4:0]                  s_step_index  = '0;
    logic [15:0]                 s_step_value  = '0;
    logic [4:0]                  s_random_pick = '0;
    logic                        m_valid;
    logic                        m_ready       = 1'b0;
    logic signed [LEVEL_W-1:0]   m_level_out;
    logic                        cfg_valid     = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index     = '0;
    logic [CFG_DATA_W-1:0]       cfg_data      = '0;

    // shadow registers
    logic        cfg_en;
    logic [5:0]  cfg_nsteps;
    logic [23:0] cfg_period;
    logic [9:0]  cfg_swing;
    logic [10:0] cfg_gate;
    logic [16:0] cfg_coef;
    logic [1:0]  cfg_dir;
    logic        cfg_unip;

    // sequencer state
    logic [15:0]     step_mem [MAX_STEPS];
    logic [4:0]      step_pos;
    logic            bounce_up;
    longint unsigned elapsed;
    longint unsigned step_len;
    logic            len_pending;
    logic [15:0]     held;
    logic [31:0]     slew_mem;

    logic [LEVEL_W-1:0] expected_levels [$];
    int  err_count      = 0;
    int  levels_checked = 0;
    int  words_sent     = 0;
    int  settings_used  = 0;
    bit  steady_source  = 1'b0;
    bit  steady_sink    = 1'b0;
    bit  sink_hold      = 1'b0;

    swing_step_sequencer_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_step_index  (s_step_index),
        .s_step_value  (s_step_value),
        .s_random_pick (s_random_pick),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_level_out   (m_level_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void seq_reset();
        cfg_en     = 1'b0;
        cfg_nsteps = 6'd16;
        cfg_period = 24'd12000;
        cfg_swing  = '0;
        cfg_gate   = 11'd819;
        cfg_coef   = 17'd65536;
        cfg_dir    = DIR_FWD;
        cfg_unip   = 1'b1;
        foreach (step_mem[i]) step_mem[i] = '0;
        step_pos    = '0;
        bounce_up   = 1'b1;
        elapsed     = 0;
        step_len    = 0;
        len_pending = 1'b1;
        held        = '0;
        slew_mem    = '0;
    endfunction

    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ENABLED:   cfg_en     = data[0];
            CFG_NUM_STEPS: cfg_nsteps = data[5:0];
            CFG_PERIOD:    cfg_period = data[23:0];
            CFG_SWING:     cfg_swing  = data[9:0];
            CFG_GATE:      cfg_gate   = data[10:0];
            CFG_SLEW:      cfg_coef   = data[16:0];
            CFG_DIRECTION: cfg_dir    = data[1:0];
            default:       cfg_unip   = data[0];
        endcase
    endfunction

    // Updates the sequencer state for one word; returns 1 when a level is due.
    function automatic bit predict_level(input logic [1:0] act, input logic [4:0] idx,
                                         input logic [15:0] val, input logic [4:0] pick,
                                         output logic [LEVEL_W-1:0] lvl);
        int              n;
        int              p;
        longint unsigned period, swing, gate, coef, d, lev;
        longint          diff, prod;
        logic [15:0]     tgt;
        lvl = '0;
        if (act == ACT_WRITE) begin
            step_mem[idx] = (val > VALUE_MAX) ? VALUE_MAX : val;
            return 1'b0;
        end
        if (act == ACT_RESTART) begin
            elapsed     = 0;
            len_pending = 1'b1;
            step_pos    = '0;
            bounce_up   = 1'b1;
            slew_mem    = '0;
            held        = step_mem[0];
            return 1'b0;
        end
        if (act != ACT_TICK) return 1'b0;
        if (!cfg_en) return 1'b1;

        n      = (cfg_nsteps < 4) ? 4 : (cfg_nsteps > MAX_STEPS) ? MAX_STEPS : int'(cfg_nsteps);
        period = (cfg_period < 4) ? 4 : cfg_period;
        swing  = (cfg_swing > 614) ? 614 : cfg_swing;
        gate   = (cfg_gate < 51) ? 51 : (cfg_gate > 1024) ? 1024 : cfg_gate;
        coef   = (cfg_coef < 1) ? 1 : (cfg_coef > 65536) ? 65536 : cfg_coef;

        elapsed++;
        if (len_pending) begin
            step_len    = period;
            held        = step_mem[step_pos];
            len_pending = 1'b0;
        end
        while (elapsed >= step_len) begin
            d = (period * swing) >> 10;
            elapsed -= step_len;
            case (cfg_dir)
                DIR_REV:  step_pos = 5'((int'(step_pos) + n - 1) % n);
                DIR_PING: begin
                    // a position past the count clamps to the last step
                    p = int'(step_pos) + (bounce_up ? 1 : -1);
                    if (p >= n - 1) begin
                        p = n - 1;
                        bounce_up = 1'b0;
                    end else if (p <= 0) begin
                        p = 0;
                        bounce_up = 1'b1;
                    end
                    step_pos = 5'(p);
                end
                DIR_RAND: step_pos = 5'(int'(pick) % n);
                default:  step_pos = 5'((int'(step_pos) + 1) % n);
            endcase
            held     = step_mem[step_pos];
            step_len = step_pos[0] ? period + d : period - d;
            if (step_len == 0) step_len = period;
        end

        tgt  = (elapsed * 1024 < gate * step_len) ? held : 16'd0;
        diff = (longint'(tgt) <<< 16) - longint'(slew_mem);
        prod = diff * longint'(coef);
        // arithmetic shift floors toward minus infinity
        slew_mem = 32'(longint'(slew_mem) + (prod >>> 16));
        lev = longint'(slew_mem >> 16);
        if (!cfg_unip) lev = lev * 2 - 32768;
        lvl = lev[LEVEL_W-1:0];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic send_word(input logic [1:0] act, input logic [4:0] idx,
                             input logic [15:0] val, input logic [4:0] pick,
                             input logic typed, input logic [LEVEL_W-1:0] typed_lvl);
        int                 gap;
        logic [LEVEL_W-1:0] lvl;
        gap = steady_source ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_step_index  <= idx;
        s_step_value  <= val;
        s_random_pick <= pick;
        do @(posedge aclk); while (!s_ready);
        if (predict_level(act, idx, val, pick, lvl))
            expected_levels.push_back(typed ? typed_lvl : lvl);
        words_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_cfg(idx, data);
    endtask

    // lets the block drain; writes and restarts give no level to wait on
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_levels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic configure_phase(input int ph);
        logic [CFG_DATA_W-1:0] v;
        cfg_write(CFG_ENABLED, (ph % 8 == 5) ? 24'd0 : 24'd1);
        case ($urandom_range(0, 5))
            0:       v = 24'd0;
            1:       v = 24'd63;
            2:       v = 24'd4;
            3:       v = 24'd32;
            default: v = 24'($urandom_range(0, 63));
        endcase
        cfg_write(CFG_NUM_STEPS, v);
        case ($urandom_range(0, 9))
            0:       v = 24'hFFFFFF;
            1:       v = 24'($urandom);
            2:       v = 24'd0;
            3:       v = 24'd12000;
            default: v = 24'($urandom_range(1, 40));
        endcase
        cfg_write(CFG_PERIOD, v);
        case ($urandom_range(0, 4))
            0:       v = 24'd0;
            1:       v = 24'd614;
            2:       v = 24'd1023;
            default: v = 24'($urandom_range(0, 1023));
        endcase
        cfg_write(CFG_SWING, v);
        case ($urandom_range(0, 5))
            0:       v = 24'd0;
            1:       v = 24'd51;
            2:       v = 24'd1024;
            3:       v = 24'd2047;
            default: v = 24'($urandom_range(0, 2047));
        endcase
        cfg_write(CFG_GATE, v);
        case ($urandom_range(0, 5))
            0:       v = 24'd0;
            1:       v = 24'd1;
            2:       v = 24'd65536;
            3:       v = 24'd131071;
            default: v = 24'($urandom_range(0, 131071));
        endcase
        cfg_write(CFG_SLEW, v);
        cfg_write(CFG_DIRECTION, 24'(ph % 4));
        cfg_write(CFG_UNIPOLAR, 24'($urandom_range(0, 1)));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // level sink
    initial begin : level_sink
        int                 stall;
        logic [LEVEL_W-1:0] want;
        wait (aresetn === 1'b1);
        forever begin
            stall = 0;
            if (sink_hold) begin
                stall = HOLD_CYCLES;
                sink_hold = 1'b0;
            end else if (!steady_sink) begin
                stall = $urandom_range(0, 4);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (expected_levels.size() == 0) begin
                report_mismatch($sformatf("level %0d with none expected", m_level_out));
            end else begin
                want = expected_levels.pop_front();
                if (m_level_out !== want)
                    report_mismatch($sformatf("level_out %0d, expected %0d",
                                              m_level_out, $signed(want)));
                levels_checked++;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int          counted;
        int          sel;
        logic [15:0] val;
        stim_row_t   row;
        seq_reset();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            if (r == ENABLE_SPLIT) begin
                settle();
                cfg_write(CFG_ENABLED, 24'd1);
                cfg_write(CFG_NUM_STEPS, 24'd4);
                cfg_write(CFG_PERIOD, 24'd4);
                cfg_write(CFG_GATE, 24'd1024);
                cfg_write(CFG_DIRECTION, 24'(DIR_FWD));
                cfg_valid <= 1'b0;
                settings_used++;
            end
            row = DIRECTED_ROWS[r];
            send_word(row.act, row.idx, row.val, row.pick, row.typed, row.lvl);
        end
        settle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            configure_phase(ph);
            steady_source = (ph % 5 == 2);
            steady_sink   = (ph % 5 == 3);
            if (ph == PRESSURE_PHASE) sink_hold = 1'b1;
            counted = 0;
            while (counted < WORDS_PER_PHASE) begin
                sel = $urandom_range(0, 99);
                case ($urandom_range(0, 9))
                    0:       val = 16'($urandom);
                    1:       val = VALUE_MAX;
                    2:       val = 16'd0;
                    default: val = 16'($urandom_range(0, 32768));
                endcase
                if (sel < 76)
                    send_word(ACT_TICK, 5'($urandom), 16'($urandom), 5'($urandom), 1'b0, '0);
                else if (sel < 90)
                    send_word(ACT_WRITE, 5'($urandom), val, 5'($urandom), 1'b0, '0);
                else if (sel < 96)
                    send_word(ACT_RESTART, 5'($urandom), 16'($urandom), 5'($urandom),
                              1'b0, '0);
                else
                    send_word(ACT_UNUSED, 5'($urandom), 16'($urandom), 5'($urandom),
                              1'b0, '0);
                if (sel < 96) counted++;
            end
            settle();
        end

        $display("Sent %0d words over %0d register settings, %0d levels checked",
                 words_sent, settings_used, levels_checked);
        $display("Covered all step orders, both polarities, clamped extremes, sink backpressure");
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
sv/ssq_pkg.sv
sv/ssq_ctrl.sv
sv/ssq_datapath.sv
sv/swing_step_sequencer_unit.sv
sv/ssq_checker.sv
test/tb.sv
